@@ src/pts_pkg.sv @@
package pts_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int NUM_TASKS  = 31;

    localparam int SLOT_W     = 5;
    localparam int TASK_W     = 5;
    localparam int TICK_W     = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int TASK_IDX_W = $clog2(NUM_TASKS + 1);
    localparam int TASK_DEPTH = NUM_TASKS + 1;

    localparam logic [SLOT_W-1:0] HIGHEST_SLOT_RST = SLOT_W'(31);
    localparam logic [TICK_W-1:0] TICK_WRAP_RST    = TICK_W'(64000);

    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_SLOT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_WRAP    = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_DELAY   = 2'd1,
        KIND_RESCHED = 2'd2,
        KIND_INSTALL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUNNABLE = 2'd0,
        ST_DELAYED  = 2'd1,
        ST_WOKEN    = 2'd2
    } task_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAKE,
        S_WAKE_DRAIN,
        S_SCAN_INIT,
        S_SCAN,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic                  latch;
        logic                  exec;
        logic                  wake_rd;
        logic [TASK_IDX_W-1:0] wake_addr;
        logic                  scan_start;
        logic                  scan_step;
        logic                  load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  scan_done;
        logic  out_free;
    } ctrl_sts_t;

endpackage

@@ src/pts_ram.sv @@
module pts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pts_ctrl.sv @@
module pts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pts_pkg::ctrl_sts_t  sts,
    output pts_pkg::ctrl_cmd_t  cmd
);

    pts_pkg::ctrl_state_t state_reg, state_next;
    logic [pts_pkg::TASK_IDX_W-1:0] wake_idx_reg, wake_idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pts_pkg::S_IDLE;
            wake_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            wake_idx_reg <= wake_idx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        wake_idx_next = wake_idx_reg;
        cmd           = '0;
        cmd.wake_addr = wake_idx_reg;
        s_ready       = 1'b0;
        case (state_reg)
            pts_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = pts_pkg::S_EXEC;
                end
            end
            pts_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.kind == pts_pkg::KIND_TICK) begin
                    wake_idx_next = pts_pkg::TASK_IDX_W'(1);
                    state_next    = pts_pkg::S_WAKE;
                end else begin
                    state_next = pts_pkg::S_SCAN_INIT;
                end
            end
            pts_pkg::S_WAKE: begin
                // one wake-time read per cycle, tasks 1 upward
                cmd.wake_rd = 1'b1;
                if (int'(wake_idx_reg) == pts_pkg::NUM_TASKS) begin
                    state_next = pts_pkg::S_WAKE_DRAIN;
                end else begin
                    wake_idx_next = wake_idx_reg + 1'b1;
                end
            end
            pts_pkg::S_WAKE_DRAIN: begin
                state_next = pts_pkg::S_SCAN_INIT;
            end
            pts_pkg::S_SCAN_INIT: begin
                cmd.scan_start = 1'b1;
                state_next     = pts_pkg::S_SCAN;
            end
            pts_pkg::S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = pts_pkg::S_RESULT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            pts_pkg::S_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = pts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/pts_datapath.sv @@
module pts_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pts_pkg::ctrl_cmd_t                cmd,
    output pts_pkg::ctrl_sts_t                sts,
    input  logic [pts_pkg::KIND_W-1:0]        s_kind,
    input  logic [pts_pkg::TICK_W-1:0]        s_delay_ticks,
    input  logic [pts_pkg::SLOT_W-1:0]        s_slot,
    input  logic [pts_pkg::TASK_W-1:0]        s_task_id,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pts_pkg::TASK_W-1:0]        m_running_task,
    output logic                              m_switched,
    output logic [pts_pkg::TICK_W-1:0]        m_tick_value,
    input  logic                              cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // configuration
    logic [pts_pkg::SLOT_W-1:0] highest_slot_reg;
    logic [pts_pkg::TICK_W-1:0] tick_wrap_reg;

    // scheduler state
    logic [pts_pkg::TASK_W-1:0]  slot_table_reg [pts_pkg::NUM_SLOTS];
    pts_pkg::task_status_t       status_reg [pts_pkg::TASK_DEPTH];
    logic [pts_pkg::TICK_W-1:0]  tick_cnt_reg;
    logic [pts_pkg::TASK_W-1:0]  current_reg;

    // latched item
    pts_pkg::kind_t              kind_reg;
    logic [pts_pkg::TICK_W-1:0]  delay_reg;
    logic [pts_pkg::SLOT_W-1:0]  slot_reg;
    logic [pts_pkg::TASK_W-1:0]  tid_reg;

    // wake compare stage
    logic                          cmp_vld_reg;
    logic [pts_pkg::TASK_IDX_W-1:0] cmp_idx_reg;
    logic [pts_pkg::TICK_W-1:0]    wake_rdata;

    // scan
    logic [pts_pkg::SLOT_IDX_W-1:0] scan_idx_reg;
    logic                           scan_done_reg;
    logic [pts_pkg::TASK_W-1:0]     pick_reg;

    // result
    logic                           m_valid_reg;
    logic [pts_pkg::TASK_W-1:0]     out_task_reg;
    logic                           out_switched_reg;
    logic [pts_pkg::TICK_W-1:0]     out_tick_reg;

    logic [pts_pkg::TICK_W-1:0]     tick_inc;
    logic [pts_pkg::TICK_W-1:0]     tick_cnt_next;
    logic [pts_pkg::TICK_W:0]       wake_sum;
    logic [pts_pkg::TICK_W-1:0]     wake_wdata;
    logic                           delay_we;
    logic                           install_ok;
    logic [pts_pkg::TASK_W-1:0]     scan_task;
    logic                           scan_occ;
    pts_pkg::task_status_t          scan_status;
    logic                           scan_hit;
    logic                           scan_last;
    logic                           wake_hit;

    always_comb begin
        tick_inc      = tick_cnt_reg + 1'b1;
        tick_cnt_next = (tick_inc == tick_wrap_reg) ? '0 : tick_inc;

        wake_sum = {1'b0, tick_cnt_reg} + {1'b0, delay_reg};
        if (wake_sum >= {1'b0, tick_wrap_reg}) begin
            wake_sum = wake_sum - {1'b0, tick_wrap_reg};
        end
        wake_wdata = wake_sum[pts_pkg::TICK_W-1:0];

        delay_we = cmd.exec && (kind_reg == pts_pkg::KIND_DELAY)
                   && (int'(current_reg) <= pts_pkg::NUM_TASKS);
        install_ok = (int'(slot_reg) < pts_pkg::NUM_SLOTS)
                     && (int'(tid_reg) <= pts_pkg::NUM_TASKS);

        wake_hit = cmp_vld_reg && (status_reg[cmp_idx_reg] == pts_pkg::ST_DELAYED)
                   && (wake_rdata == tick_cnt_reg);

        scan_task   = slot_table_reg[scan_idx_reg];
        scan_occ    = (scan_task != '0) && (int'(scan_task) <= pts_pkg::NUM_TASKS);
        scan_status = status_reg[pts_pkg::TASK_IDX_W'(scan_task)];
        scan_hit    = scan_occ && ((scan_status == pts_pkg::ST_RUNNABLE)
                                   || (scan_status == pts_pkg::ST_WOKEN));
        scan_last   = int'(scan_idx_reg) == pts_pkg::NUM_SLOTS - 1;
    end

    pts_ram #(
        .WIDTH (pts_pkg::TICK_W),
        .DEPTH (pts_pkg::TASK_DEPTH)
    ) u_wake_ram (
        .aclk  (aclk),
        .we    (delay_we),
        .waddr (pts_pkg::TASK_IDX_W'(current_reg)),
        .wdata (wake_wdata),
        .re    (cmd.wake_rd),
        .raddr (cmd.wake_addr),
        .rdata (wake_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_slot_reg <= pts_pkg::HIGHEST_SLOT_RST;
            tick_wrap_reg    <= pts_pkg::TICK_WRAP_RST;
            for (int i = 0; i < pts_pkg::NUM_SLOTS; i++) begin
                slot_table_reg[i] <= '0;
            end
            for (int i = 0; i < pts_pkg::TASK_DEPTH; i++) begin
                status_reg[i] <= pts_pkg::ST_RUNNABLE;
            end
            tick_cnt_reg  <= '0;
            current_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    pts_pkg::CFG_HIGHEST_SLOT: highest_slot_reg <= cfg_wdata[pts_pkg::SLOT_W-1:0];
                    pts_pkg::CFG_TICK_WRAP:    tick_wrap_reg    <= cfg_wdata[pts_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.exec) begin
                case (kind_reg)
                    pts_pkg::KIND_TICK: tick_cnt_reg <= tick_cnt_next;
                    pts_pkg::KIND_DELAY: begin
                        if (delay_we) begin
                            status_reg[pts_pkg::TASK_IDX_W'(current_reg)] <= pts_pkg::ST_DELAYED;
                        end
                    end
                    pts_pkg::KIND_INSTALL: begin
                        if (install_ok) begin
                            slot_table_reg[pts_pkg::SLOT_IDX_W'(slot_reg)] <= tid_reg;
                        end
                    end
                    default: ;
                endcase
            end

            cmp_vld_reg <= cmd.wake_rd;
            if (wake_hit) begin
                status_reg[cmp_idx_reg] <= pts_pkg::ST_WOKEN;
            end

            if (cmd.scan_start) begin
                scan_done_reg <= int'(highest_slot_reg) >= pts_pkg::NUM_SLOTS;
            end else if (cmd.scan_step) begin
                if (scan_occ && scan_status == pts_pkg::ST_WOKEN) begin
                    status_reg[pts_pkg::TASK_IDX_W'(scan_task)] <= pts_pkg::ST_RUNNABLE;
                end
                scan_done_reg <= scan_hit || scan_last;
            end

            if (cmd.load_out) begin
                current_reg <= pick_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg  <= pts_pkg::kind_t'(s_kind);
            delay_reg <= s_delay_ticks;
            slot_reg  <= s_slot;
            tid_reg   <= s_task_id;
        end
        if (cmd.wake_rd) begin
            cmp_idx_reg <= cmd.wake_addr;
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= pts_pkg::SLOT_IDX_W'(highest_slot_reg);
            pick_reg     <= current_reg;
        end else if (cmd.scan_step) begin
            if (scan_occ) begin
                pick_reg <= scan_task;
            end
            if (!scan_last) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (cmd.load_out) begin
            out_task_reg     <= pick_reg;
            out_switched_reg <= pick_reg != current_reg;
            out_tick_reg     <= tick_cnt_reg;
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.scan_done = scan_done_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_running_task = out_task_reg;
    assign m_switched     = out_switched_reg;
    assign m_tick_value   = out_tick_reg;

endmodule

@@ src/priority_task_scheduler_with_delay_timer_core.sv @@
// A tick beat adds a wake-time sweep of one task per cycle through the wake
//   RAM read port.
// Throughput: one item at a time; the next input beat is taken once the
//   result is loaded into the output register, which holds it until taken.
// Reset (aresetn, synchronous, active low): empty slot table, all tasks
//   runnable, tick counter and running task zero, registers to their defaults.
module priority_task_scheduler_with_delay_timer_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input channel: one beat per scheduler event
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pts_pkg::KIND_W-1:0]      s_kind,
    input  logic [pts_pkg::TICK_W-1:0]      s_delay_ticks,
    input  logic [pts_pkg::SLOT_W-1:0]      s_slot,
    input  logic [pts_pkg::TASK_W-1:0]      s_task_id,

    // result channel: one beat per accepted input beat
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pts_pkg::TASK_W-1:0]      m_running_task,
    output logic                            m_switched,
    output logic [pts_pkg::TICK_W-1:0]      m_tick_value,

    // configuration write port: index 0 highest slot, index 1 tick wrap
    input  logic                            cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    pts_pkg::ctrl_cmd_t cmd;
    pts_pkg::ctrl_sts_t sts;

    // Sequencer: take the beat, apply it (tick advance, delay write or slot
    // install), sweep the wake times on a tick, scan the slots from the
    // highest slot upward, then hand the pick to the output register.
    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: slot table, task status, wake RAM, tick counter, running task
    // and the result register.
    pts_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_kind         (s_kind),
        .s_delay_ticks  (s_delay_ticks),
        .s_slot         (s_slot),
        .s_task_id      (s_task_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running_task (m_running_task),
        .m_switched     (m_switched),
        .m_tick_value   (m_tick_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

endmodule
